FILE: hdl/ahs_pkg.sv
// ----------------------------------------------------------------------------
// Alloy heat stencil package
// Shared widths, codes, request and response types, and small helper
// functions for the heat stencil sweep unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ahs_pkg;

  // Grid storage.
  localparam int unsigned MaxCells  = 4096;
  localparam int unsigned AddrW     = $clog2(MaxCells);
  localparam int unsigned CountW    = AddrW + 1;

  // Field widths.
  localparam int unsigned TempW     = 24;
  localparam int unsigned ShareW    = 7;
  localparam int unsigned SharePackW = 3 * ShareW;
  localparam int unsigned CoefW     = 10;
  localparam int unsigned DimW      = 13;
  localparam int unsigned SweepW    = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 24;

  // Arithmetic widths: four neighbours of temp times share, then times coef.
  localparam int unsigned AccW      = TempW + ShareW + 2;
  localparam int unsigned ProdW     = AccW + CoefW;
  localparam int unsigned QuotW     = ProdW - 8;
  localparam int unsigned DivisorW  = 9;
  localparam int unsigned Lanes     = 3;

  localparam logic [TempW-1:0] TempMax = '1;

  // Reciprocal division by 25 or 75 of a dividend below 75 x 2^24.
  localparam int unsigned RecipInW     = 31;
  localparam int unsigned RecipMagW    = 32;
  localparam int unsigned RecipProdW   = RecipInW + RecipMagW;
  localparam int unsigned RecipShift25 = 36;
  localparam int unsigned RecipShift75 = 38;
  localparam logic [RecipMagW-1:0] RecipMagic25 = 32'd2748779070;
  localparam logic [RecipMagW-1:0] RecipMagic75 = 32'd3665038760;
  localparam logic [QuotW-1:0]     RecipLimit25 = QuotW'(25) << TempW;
  localparam logic [QuotW-1:0]     RecipLimit75 = QuotW'(75) << TempW;
  localparam logic [QuotW-1:0]     RecipSatQuot = QuotW'(1) << TempW;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgCoefFirst  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCoefSecond = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCoefThird  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSrcFirst   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSrcLast    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgWidth      = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgHeight     = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSweeps     = 3'd7;

  typedef enum logic [1:0] {
    OpLoad = 2'd0,
    OpRun  = 2'd1,
    OpRead = 2'd2,
    OpNone = 2'd3
  } ahs_op_e;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StBadIndex  = 2'd1,
    StTooLarge  = 2'd2,
    StSaturated = 2'd3
  } ahs_status_e;

  typedef enum logic [3:0] {
    SIdle,
    SRead,
    SCell,
    SGather,
    SMul,
    SDiv,
    SDivWait,
    SWrite,
    SResult
  } ahs_state_e;

  typedef struct packed {
    ahs_op_e           operation;
    logic [AddrW-1:0]  cell_index;
    logic [TempW-1:0]  cell_temp;
    logic [ShareW-1:0] share_first;
    logic [ShareW-1:0] share_second;
    logic [ShareW-1:0] share_third;
  } ahs_req_t;

  typedef struct packed {
    logic [AddrW-1:0] echo_index;
    logic [TempW-1:0] temp_out;
    ahs_status_e      status;
  } ahs_rsp_t;

  // Handshake between the sequencer and the divider.
  typedef struct packed {
    logic                start;
    logic [DivisorW-1:0] divisor;
  } ahs_div_ctl_t;

  // Divisor after the fixed shift by eight: one hundred per neighbour.
  function automatic logic [DivisorW-1:0] ahs_divisor(input logic [2:0] n);
    logic [DivisorW-1:0] d;
    case (n)
      3'd1:    d = 9'd100;
      3'd2:    d = 9'd200;
      3'd3:    d = 9'd300;
      3'd4:    d = 9'd400;
      default: d = 9'd100;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/ahs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ahs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ahs_div.sv
// ----------------------------------------------------------------------------
// Three-lane reciprocal divider
// Divides three dividends by one shared divisor of 100, 200, 300 or 400,
// using a shift, a clamp and a reciprocal multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module ahs_div
  import ahs_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire ahs_div_ctl_t ctl_i,
  input  wire logic [QuotW-1:0] dividend_i [Lanes],
  output logic              done_o,
  output logic [QuotW-1:0]  quot_o [Lanes]
);

  logic                  stage1_q, stage2_q;
  logic                  sel75_q;
  logic [2:0]            shift;
  logic                  sel75;
  logic [RecipMagW-1:0]  magic;
  logic                  big_q [Lanes];
  logic [RecipInW-1:0]   y_q [Lanes];
  logic [RecipProdW-1:0] p_q [Lanes];

  // Stage flags: the start passes through stage1_q into stage2_q, which drives done_o.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage1_q <= 1'b0;
      stage2_q <= 1'b0;
    end else begin
      stage1_q <= ctl_i.start;
      stage2_q <= stage1_q;
    end
  end

  // Split the divisor into a power of two and an odd factor of 25 or 75.
  always_comb begin
    case (ctl_i.divisor)
      DivisorW'(200): begin
        shift = 3'd3;
        sel75 = 1'b0;
      end
      DivisorW'(300): begin
        shift = 3'd2;
        sel75 = 1'b1;
      end
      DivisorW'(400): begin
        shift = 3'd4;
        sel75 = 1'b0;
      end
      default: begin
        shift = 3'd2;
        sel75 = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      sel75_q <= sel75;
    end
  end

  assign magic = sel75_q ? RecipMagic75 : RecipMagic25;

  // Per lane: shift, clamp quotients that saturate anyway, then multiply.
  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    logic [QuotW-1:0]      scaled;
    logic [QuotW-1:0]      limit;
    logic                  big;
    logic [RecipProdW-1:0] q_full;

    assign scaled = dividend_i[l] >> shift;
    assign limit  = sel75 ? RecipLimit75 : RecipLimit25;
    assign big    = scaled >= limit;

    always_ff @(posedge clk_i) begin
      if (ctl_i.start) begin
        big_q[l] <= big;
        y_q[l]   <= big ? '0 : scaled[RecipInW-1:0];
      end
      if (stage1_q) begin
        p_q[l] <= RecipProdW'(y_q[l]) * RecipProdW'(magic);
      end
    end

    assign q_full    = sel75_q ? (p_q[l] >> RecipShift75) : (p_q[l] >> RecipShift25);
    assign quot_o[l] = big_q[l] ? RecipSatQuot : q_full[QuotW-1:0];
  end

  assign done_o = stage2_q;

endmodule

`default_nettype wire

FILE: hdl/alloy_heat_stencil_sweep_unit.sv
// ----------------------------------------------------------------------------
// Alloy heat stencil sweep unit
// Holds a grid of cells in ping-pong temperature memories and a share
// memory, and runs Jacobi heat diffusion sweeps over it on command.
// ----------------------------------------------------------------------------
// A load request's response passes through the result register into the
// output register once the output is free, and a read's first passes the
// memory's registered read port. A run request walks sweep_count sweeps over
// every cell: source cells take their fixed temperatures, and each inner cell
// gathers its neighbours through the single read port of the memories, one
// read per neighbour, and then passes through the reciprocal divider. One
// request is worked on at a time; a new request is accepted while the previous
// response still waits in the output register. There is no clearing pass:
// cells must be loaded before they are read or swept.
`default_nettype none

module alloy_heat_stencil_sweep_unit
  import ahs_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire ahs_req_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output ahs_rsp_t                 out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers.
  logic [CoefW-1:0]  coef_q [Lanes];
  logic [TempW-1:0]  src_first_q, src_last_q;
  logic [DimW-1:0]   width_q, height_q;
  logic [SweepW-1:0] sweeps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0]   <= 10'd192;
      coef_q[1]   <= 10'd256;
      coef_q[2]   <= 10'd320;
      src_first_q <= 24'd25600;
      src_last_q  <= 24'd25600;
      width_q     <= 13'd64;
      height_q    <= 13'd32;
      sweeps_q    <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgCoefFirst:  coef_q[0]   <= cfg_data_i[CoefW-1:0];
        CfgCoefSecond: coef_q[1]   <= cfg_data_i[CoefW-1:0];
        CfgCoefThird:  coef_q[2]   <= cfg_data_i[CoefW-1:0];
        CfgSrcFirst:   src_first_q <= cfg_data_i[TempW-1:0];
        CfgSrcLast:    src_last_q  <= cfg_data_i[TempW-1:0];
        CfgWidth:      width_q     <= cfg_data_i[DimW-1:0];
        CfgHeight:     height_q    <= cfg_data_i[DimW-1:0];
        CfgSweeps:     sweeps_q    <= cfg_data_i[SweepW-1:0];
        default: ;
      endcase
    end
  end

  // Grid size checks.
  logic [2*DimW-1:0] cells;
  logic              too_big;
  logic              idx_bad;

  assign cells   = width_q * height_q;
  assign too_big = cells > (2*DimW)'(MaxCells);
  assign idx_bad = (2*DimW)'(in_data_i.cell_index) >= cells;

  // Sequencer state.
  ahs_state_e         state_q, state_d;
  logic [AddrW-1:0]   cell_q, cell_d;
  logic [DimW-1:0]    col_q, col_d;
  logic [DimW-1:0]    row_q, row_d;
  logic [CountW-1:0]  cells_q, cells_d;
  logic [SweepW-1:0]  left_q, left_d;
  logic               sat_q, sat_d;
  logic               active_q, active_d;
  logic [2:0]         nb_q, nb_d;
  logic               pend_q, pend_d;
  logic [2:0]         n_q, n_d;
  logic [AccW-1:0]    acc_q [Lanes];
  logic [AccW-1:0]    acc_d [Lanes];
  logic [ProdW-1:0]   prod_q [Lanes];
  logic [TempW-1:0]   wval_q, wval_d;
  ahs_rsp_t           res_q, res_d;
  ahs_rsp_t           out_q;
  logic               out_valid_q, out_valid_d;
  logic               out_load;

  // Memory ports.
  logic                  wr_en, wr_bank_b, sh_we, rd_en;
  logic [AddrW-1:0]      wr_addr, sh_addr, rd_addr;
  logic [TempW-1:0]      wr_temp, rd_temp_a, rd_temp_b, rd_temp;
  logic [SharePackW-1:0] sh_wdata, rd_share;

  ahs_ram #(.Width(TempW), .Depth(MaxCells)) u_bank_a (
    .clk_i   (clk_i),
    .we_i    (wr_en && !wr_bank_b),
    .waddr_i (wr_addr),
    .wdata_i (wr_temp),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_temp_a)
  );

  ahs_ram #(.Width(TempW), .Depth(MaxCells)) u_bank_b (
    .clk_i   (clk_i),
    .we_i    (wr_en && wr_bank_b),
    .waddr_i (wr_addr),
    .wdata_i (wr_temp),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_temp_b)
  );

  ahs_ram #(.Width(SharePackW), .Depth(MaxCells)) u_shares (
    .clk_i   (clk_i),
    .we_i    (sh_we),
    .waddr_i (sh_addr),
    .wdata_i (sh_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_share)
  );

  // The active bank does not change between a read and its data.
  assign rd_temp = active_q ? rd_temp_b : rd_temp_a;

  // Divider.
  ahs_div_ctl_t     div_ctl;
  logic             div_done;
  logic [QuotW-1:0] div_in [Lanes];
  logic [QuotW-1:0] quot [Lanes];

  for (genvar l = 0; l < Lanes; l++) begin : g_div_in
    assign div_in[l] = prod_q[l][ProdW-1:8];
  end

  ahs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (div_in),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Sum of the three quotients with saturation.
  logic [QuotW+1:0] qsum;
  logic             qsat;

  assign qsum = (QuotW+2)'(quot[0]) + (QuotW+2)'(quot[1]) + (QuotW+2)'(quot[2]);
  assign qsat = qsum > (QuotW+2)'(TempMax);

  // Neighbour addressing for the current cell.
  logic             nb_exists;
  logic [AddrW-1:0] nb_addr;

  always_comb begin
    case (nb_q)
      3'd0: begin
        nb_exists = row_q != '0;
        nb_addr   = cell_q - width_q[AddrW-1:0];
      end
      3'd1: begin
        nb_exists = (row_q + 1'b1) < height_q;
        nb_addr   = cell_q + width_q[AddrW-1:0];
      end
      3'd2: begin
        nb_exists = col_q != '0;
        nb_addr   = cell_q - 1'b1;
      end
      3'd3: begin
        nb_exists = (col_q + 1'b1) < width_q;
        nb_addr   = cell_q + 1'b1;
      end
      default: begin
        nb_exists = 1'b0;
        nb_addr   = cell_q;
      end
    endcase
  end

  // Gathered neighbour contribution, one per metal.
  logic [AccW-1:0] contrib [Lanes];

  for (genvar l = 0; l < Lanes; l++) begin : g_contrib
    assign contrib[l] = AccW'(rd_temp) * AccW'(rd_share[l*ShareW +: ShareW]);
  end

  assign in_stall_o = state_q != SIdle;
  assign out_load   = (state_q == SResult) && (!out_valid_q || !out_stall_i);

  // Next state and memory control.
  always_comb begin
    state_d   = state_q;
    cell_d    = cell_q;
    col_d     = col_q;
    row_d     = row_q;
    cells_d   = cells_q;
    left_d    = left_q;
    sat_d     = sat_q;
    active_d  = active_q;
    nb_d      = nb_q;
    pend_d    = pend_q;
    n_d       = n_q;
    acc_d     = acc_q;
    wval_d    = wval_q;
    res_d     = res_q;
    wr_en     = 1'b0;
    wr_bank_b = active_q;
    wr_addr   = cell_q;
    wr_temp   = wval_q;
    sh_we     = 1'b0;
    sh_addr   = in_data_i.cell_index;
    sh_wdata  = {in_data_i.share_third, in_data_i.share_second, in_data_i.share_first};
    rd_en     = 1'b0;
    rd_addr   = nb_addr;
    div_ctl   = '{start: 1'b0, divisor: ahs_divisor(n_q)};

    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          res_d = '{echo_index: in_data_i.cell_index, temp_out: '0, status: StOk};
          state_d = SResult;
          if (in_data_i.operation == OpNone) begin
            res_d.status = StOk;
          end else if (too_big) begin
            res_d.status = StTooLarge;
          end else if (in_data_i.operation == OpRun) begin
            if ((cells != '0) && (sweeps_q != '0)) begin
              cell_d  = '0;
              col_d   = '0;
              row_d   = '0;
              cells_d = cells[CountW-1:0];
              left_d  = sweeps_q;
              sat_d   = 1'b0;
              state_d = SCell;
            end
          end else if (idx_bad) begin
            res_d.status = StBadIndex;
          end else if (in_data_i.operation == OpLoad) begin
            // Load into the active bank.
            wr_en     = 1'b1;
            wr_bank_b = active_q;
            wr_addr   = in_data_i.cell_index;
            wr_temp   = in_data_i.cell_temp;
            sh_we     = 1'b1;
          end else begin
            rd_en   = 1'b1;
            rd_addr = in_data_i.cell_index;
            state_d = SRead;
          end
        end
      end

      SRead: begin
        res_d.temp_out = rd_temp;
        state_d        = SResult;
      end

      SCell: begin
        // Source cells take their fixed temperatures directly.
        if (cell_q == '0) begin
          wval_d  = src_first_q;
          state_d = SWrite;
        end else if ({1'b0, cell_q} == (cells_q - 1'b1)) begin
          wval_d  = src_last_q;
          state_d = SWrite;
        end else begin
          nb_d    = '0;
          pend_d  = 1'b0;
          n_d     = '0;
          for (int l = 0; l < Lanes; l++) begin
            acc_d[l] = '0;
          end
          state_d = SGather;
        end
      end

      SGather: begin
        // Issue one neighbour read a cycle and accumulate the previous one.
        if (pend_q) begin
          for (int l = 0; l < Lanes; l++) begin
            acc_d[l] = acc_q[l] + contrib[l];
          end
        end
        if (nb_q == 3'd4) begin
          pend_d  = 1'b0;
          state_d = SMul;
        end else begin
          rd_en  = nb_exists;
          pend_d = nb_exists;
          if (nb_exists) begin
            n_d = n_q + 1'b1;
          end
          nb_d = nb_q + 1'b1;
        end
      end

      SMul: begin
        state_d = SDiv;
      end

      SDiv: begin
        div_ctl.start = 1'b1;
        state_d       = SDivWait;
      end

      SDivWait: begin
        if (div_done) begin
          if (qsat) begin
            wval_d = TempMax;
            sat_d  = 1'b1;
          end else begin
            wval_d = qsum[TempW-1:0];
          end
          state_d = SWrite;
        end
      end

      SWrite: begin
        // Write the new temperature into the inactive bank and advance.
        wr_en     = 1'b1;
        wr_bank_b = !active_q;
        wr_addr   = cell_q;
        wr_temp   = wval_q;
        if ({1'b0, cell_q} == (cells_q - 1'b1)) begin
          active_d = !active_q;
          cell_d   = '0;
          col_d    = '0;
          row_d    = '0;
          if (left_q == SweepW'(1)) begin
            res_d.status = sat_q ? StSaturated : StOk;
            state_d      = SResult;
          end else begin
            left_d  = left_q - 1'b1;
            state_d = SCell;
          end
        end else begin
          cell_d = cell_q + 1'b1;
          if ((col_q + 1'b1) == width_q) begin
            col_d = '0;
            row_d = row_q + 1'b1;
          end else begin
            col_d = col_q + 1'b1;
          end
          state_d = SCell;
        end
      end

      SResult: begin
        if (out_load) begin
          state_d = SIdle;
        end
      end

      default: state_d = SIdle;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  // Payload and loop registers.
  always_ff @(posedge clk_i) begin
    cell_q  <= cell_d;
    col_q   <= col_d;
    row_q   <= row_d;
    cells_q <= cells_d;
    left_q  <= left_d;
    sat_q   <= sat_d;
    nb_q    <= nb_d;
    n_q     <= n_d;
    acc_q   <= acc_d;
    wval_q  <= wval_d;
    res_q   <= res_d;
    if (state_q == SMul) begin
      for (int l = 0; l < Lanes; l++) begin
        prod_q[l] <= ProdW'(coef_q[l]) * ProdW'(acc_q[l]);
      end
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
